### rtl/gf16mpi_pkg.sv
package gf16mpi_pkg;

  localparam int FIELD_W = 16;
  localparam int PROD_W = 2 * FIELD_W - 1;
  localparam int RED_W = 6;
  localparam int FOLD1_W = FIELD_W - 1 + RED_W;
  localparam int HIGH2_W = FOLD1_W - FIELD_W;
  localparam int FOLD2_W = HIGH2_W + RED_W;
  localparam int CNT_W = 4;

  localparam logic [RED_W-1:0] REDUCE_LOW = 6'h2B;
  localparam logic [FIELD_W-1:0] INV_EXP = 16'hFFFE;
  localparam logic [FIELD_W-1:0] FIELD_ONE = 16'h0001;
  localparam logic [CNT_W-1:0] POW_ROUNDS_M1 = 4'd15;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_POW = 2'd1,
    OP_INV = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_HOLD = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
    op_t  mode;
  } dp_cmd_t;

  // carry-less product folded twice by x^16 = x^5 + x^3 + x + 1
  function automatic logic [FIELD_W-1:0] gf_mul(input logic [FIELD_W-1:0] x,
                                                input logic [FIELD_W-1:0] y);
    logic [PROD_W-1:0] p;
    logic [FIELD_W-2:0] h1;
    logic [FOLD1_W-1:0] t1;
    logic [HIGH2_W-1:0] h2;
    logic [FOLD2_W-1:0] t2;
    p = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (y[i]) begin
        p = p ^ ({{(PROD_W-FIELD_W){1'b0}}, x} << i);
      end
    end
    h1 = p[PROD_W-1:FIELD_W];
    t1 = '0;
    for (int j = 0; j < RED_W; j++) begin
      if (REDUCE_LOW[j]) begin
        t1 = t1 ^ ({{RED_W{1'b0}}, h1} << j);
      end
    end
    h2 = t1[FOLD1_W-1:FIELD_W];
    t2 = '0;
    for (int k = 0; k < RED_W; k++) begin
      if (REDUCE_LOW[k]) begin
        t2 = t2 ^ ({{RED_W{1'b0}}, h2} << k);
      end
    end
    return p[FIELD_W-1:0] ^ t1[FIELD_W-1:0] ^ {{(FIELD_W-FOLD2_W){1'b0}}, t2};
  endfunction

endpackage

### rtl/gf16mpi_dp.sv
module gf16mpi_dp (
  input  logic                           clk,
  input  gf16mpi_pkg::dp_cmd_t           cmd,
  input  logic [gf16mpi_pkg::FIELD_W-1:0] in_operand_a,
  input  logic [gf16mpi_pkg::FIELD_W-1:0] in_operand_b,
  output logic [gf16mpi_pkg::FIELD_W-1:0] out_result
);

  logic [gf16mpi_pkg::FIELD_W-1:0] acc_r, acc_nxt;
  logic [gf16mpi_pkg::FIELD_W-1:0] base_r, base_nxt;
  logic [gf16mpi_pkg::FIELD_W-1:0] exp_r, exp_nxt;
  logic [gf16mpi_pkg::FIELD_W-1:0] res_r, res_nxt;
  logic [gf16mpi_pkg::FIELD_W-1:0] acc_step;
  logic [gf16mpi_pkg::FIELD_W-1:0] prod;
  logic [gf16mpi_pkg::FIELD_W-1:0] sq;

  assign prod = gf16mpi_pkg::gf_mul(acc_r, base_r);
  assign sq = gf16mpi_pkg::gf_mul(base_r, base_r);
  assign acc_step = exp_r[0] ? prod : acc_r;

  always_comb begin
    acc_nxt = acc_r;
    base_nxt = base_r;
    exp_nxt = exp_r;
    res_nxt = res_r;
    if (cmd.load) begin
      base_nxt = in_operand_a;
      unique case (cmd.mode)
        gf16mpi_pkg::OP_MUL: begin
          acc_nxt = in_operand_b;
          exp_nxt = gf16mpi_pkg::FIELD_ONE;
        end
        gf16mpi_pkg::OP_POW: begin
          acc_nxt = gf16mpi_pkg::FIELD_ONE;
          exp_nxt = in_operand_b;
        end
        gf16mpi_pkg::OP_INV: begin
          acc_nxt = gf16mpi_pkg::FIELD_ONE;
          exp_nxt = gf16mpi_pkg::INV_EXP;
        end
        default: begin
          acc_nxt = '0;
          exp_nxt = '0;
        end
      endcase
    end else if (cmd.step) begin
      acc_nxt = acc_step;
      base_nxt = sq;
      exp_nxt = {1'b0, exp_r[gf16mpi_pkg::FIELD_W-1:1]};
    end
    if (cmd.out_load) begin
      res_nxt = cmd.step ? acc_step : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    base_r <= base_nxt;
    exp_r <= exp_nxt;
    res_r <= res_nxt;
  end

  assign out_result = res_r;

endmodule

### rtl/gf16mpi_ctrl.sv
module gf16mpi_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gf16mpi_pkg::dp_cmd_t cmd
);

  gf16mpi_pkg::state_t state_r, state_nxt;
  logic [gf16mpi_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  gf16mpi_pkg::op_t op;

  assign op = gf16mpi_pkg::op_t'(in_cmd);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    cmd.out_load = 1'b0;
    cmd.mode = op;
    unique case (state_r)
      gf16mpi_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = gf16mpi_pkg::S_RUN;
          unique case (op)
            gf16mpi_pkg::OP_POW,
            gf16mpi_pkg::OP_INV: cnt_nxt = gf16mpi_pkg::POW_ROUNDS_M1;
            default:             cnt_nxt = '0;
          endcase
        end
      end
      gf16mpi_pkg::S_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - {{(gf16mpi_pkg::CNT_W-1){1'b0}}, 1'b1};
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = gf16mpi_pkg::S_IDLE;
        end else begin
          state_nxt = gf16mpi_pkg::S_HOLD;
        end
      end
      gf16mpi_pkg::S_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = gf16mpi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gf16mpi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gf16mpi_pkg::S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_hold_needs_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gf16mpi_pkg::S_HOLD |-> out_valid_r)
    else $error("result held back while output slot free");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gf16mpi_pkg::S_IDLE |-> cnt_r == '0)
    else $error("round count left over in idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("pending result overwritten");
`endif

endmodule

### rtl/gf2_16_mul_pow_inv.sv
// flow: multiply and the unused code run one round, power and inverse 16 rounds,
// and the result waits in the hold state while the output register is still full
// throughput: one item at a time; power and inverse each run as
// 16 square-and-multiply rounds on the shared pair of field multipliers
// a finished result sits in the output register while the next item is taken
// reset: synchronous active-low rst_n clears the controller and output valid
module gf2_16_mul_pow_inv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result
);

  gf16mpi_pkg::dp_cmd_t cmd;

  gf16mpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  gf16mpi_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_result   (out_result)
  );

endmodule
